### rtl/core/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and codes for the clip rectangle region table.
// ----------------------------------------------------------------------------
package crt_pkg;

	typedef enum logic [2:0] {
		FN_ADD   = 3'd0,
		FN_SUB   = 3'd1,
		FN_QUERY = 3'd2,
		FN_CLEAR = 3'd3,
		FN_SET   = 3'd4,
		FN_READ  = 3'd5
	} func_t;

	// working edge: covers operand edges with negative sizes
	typedef logic signed [17:0] edge_t;
	// stored edge: -32768 .. 65534
	typedef logic signed [16:0] sedge_t;

	typedef struct packed {
		edge_t x1;
		edge_t y1;
		edge_t x2;
		edge_t y2;
	} rect_t;

	typedef struct packed {
		sedge_t x1;
		sedge_t y1;
		sedge_t x2;
		sedge_t y2;
	} ent_t;

	localparam int unsigned ENT_W = $bits(ent_t);

	function automatic rect_t ent_to_rect(input ent_t e);
		rect_t r;
		r.x1 = edge_t'(e.x1);
		r.y1 = edge_t'(e.y1);
		r.x2 = edge_t'(e.x2);
		r.y2 = edge_t'(e.y2);
		return r;
	endfunction

	function automatic ent_t rect_to_ent(input rect_t r);
		ent_t e;
		e.x1 = r.x1[16:0];
		e.y1 = r.y1[16:0];
		e.x2 = r.x2[16:0];
		e.y2 = r.y2[16:0];
		return e;
	endfunction

	function automatic logic overlap(input rect_t a, input rect_t b);
		return !(a.x2 <= b.x1 || b.x2 <= a.x1 || a.y2 <= b.y1 || b.y2 <= a.y1);
	endfunction

	function automatic logic touch(input rect_t a, input rect_t b);
		return (a.y1 == b.y1 && a.y2 == b.y2 && (a.x2 == b.x1 || b.x2 == a.x1)) ||
			(a.x1 == b.x1 && a.x2 == b.x2 && (a.y2 == b.y1 || b.y2 == a.y1));
	endfunction

	function automatic rect_t hull(input rect_t a, input rect_t b);
		rect_t r;
		r.x1 = (a.x1 < b.x1) ? a.x1 : b.x1;
		r.y1 = (a.y1 < b.y1) ? a.y1 : b.y1;
		r.x2 = (a.x2 > b.x2) ? a.x2 : b.x2;
		r.y2 = (a.y2 > b.y2) ? a.y2 : b.y2;
		return r;
	endfunction

endpackage

### rtl/core/crt_ram.sv
// ----------------------------------------------------------------------------
// crt_ram
// Single write port, single registered read port rectangle store.
// ----------------------------------------------------------------------------
module crt_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [crt_pkg::ENT_W-1:0]    wdata,
	input  logic [AW-1:0]                raddr,
	output logic [crt_pkg::ENT_W-1:0]    rdata
);

	logic [crt_pkg::ENT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/clip_rectangle_region_table.sv
// ----------------------------------------------------------------------------
// clip_rectangle_region_table
// Ordered clip rectangle table with add, subtract, query, clear, set, read.
// ----------------------------------------------------------------------------
// One input word carries an operation and an operand rectangle; each word
// produces exactly one result word with the count and bounding box.
// Both channels use valid/ready. in_ready is high only while the sequencer
// is idle, so one word is in work at a time.
// Every table access goes through one read port with a registered output,
// so each visited entry takes a read step and then an evaluate or write step.
// Query scans the entries until a hit, read fetches one, clear resets the count;
// add runs merge passes, each with a removal shift, then an insert shift;
// subtract keeps entries and up to four fragments per overlapped entry in
// scratch and copies them back. All end with a bounding box scan and an output load.
// A held result waits in the output register while the next word is
// accepted; the sequencer stalls at its last step until the result is taken.
// Reset clears the count and the handshake state; table contents are not
// cleared and are never read before being written.
// ----------------------------------------------------------------------------
module clip_rectangle_region_table #(
	parameter int unsigned MAX_RECTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic signed [15:0] rect_w,
	input  logic signed [15:0] rect_h,
	input  logic [5:0]         entry_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic               dropped,
	output logic [6:0]         rect_count,
	output logic signed [15:0] bbox_x,
	output logic signed [15:0] bbox_y,
	output logic [16:0]        bbox_w,
	output logic [16:0]        bbox_h,
	output logic               entry_valid,
	output logic signed [15:0] entry_x,
	output logic signed [15:0] entry_y,
	output logic [16:0]        entry_w,
	output logic [16:0]        entry_h
);

	localparam int unsigned AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int unsigned CW = $clog2(MAX_RECTS + 1);
	localparam int unsigned IW = (CW > 6) ? CW : 6;

	typedef enum logic [21:0] {
		ST_IDLE  = 22'h000001,
		ST_M_RD  = 22'h000002,
		ST_M_EV  = 22'h000004,
		ST_SH_RD = 22'h000008,
		ST_SH_WR = 22'h000010,
		ST_P_RD  = 22'h000020,
		ST_P_EV  = 22'h000040,
		ST_U_RD  = 22'h000080,
		ST_U_WR  = 22'h000100,
		ST_S_RD  = 22'h000200,
		ST_S_EV  = 22'h000400,
		ST_S_FR  = 22'h000800,
		ST_C_RD  = 22'h001000,
		ST_C_WR  = 22'h002000,
		ST_Q_RD  = 22'h004000,
		ST_Q_EV  = 22'h008000,
		ST_E_RD  = 22'h010000,
		ST_E_EV  = 22'h020000,
		ST_B_ST  = 22'h040000,
		ST_B_RD  = 22'h080000,
		ST_B_EV  = 22'h100000,
		ST_DONE  = 22'h200000
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q, i_q, n_q, pos_q;
	logic [1:0] f_q;
	logic [5:0] idx_q;
	crt_pkg::rect_t nr_q, a_q, c_q, bb_q;
	logic hit_q, drop_q, ev_q;
	crt_pkg::ent_t ent_q;

	logic mwe, swe;
	logic [AW-1:0] mwaddr, mraddr, swaddr, sraddr;
	logic [crt_pkg::ENT_W-1:0] mwdata, mrdata, swdata, srdata;

	crt_pkg::rect_t op, e, s_a, piece, cut;
	logic piece_ok, push, full;
	logic [CW-1:0] i_p1, i_m1, rev_idx;
	logic [17:0] bb_w, bb_h, en_w, en_h;

	crt_ram #(.DEPTH(MAX_RECTS), .AW(AW)) u_main (
		.clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
		.raddr(mraddr), .rdata(mrdata)
	);

	crt_ram #(.DEPTH(MAX_RECTS), .AW(AW)) u_scratch (
		.clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata),
		.raddr(sraddr), .rdata(srdata)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign i_p1     = i_q + CW'(1);
	assign i_m1     = i_q - CW'(1);
	assign rev_idx  = n_q - CW'(1) - i_q;
	assign full     = (n_q >= CW'(MAX_RECTS));
	assign e        = crt_pkg::ent_to_rect(crt_pkg::ent_t'(mrdata));

	always_comb begin
		op.x1 = crt_pkg::edge_t'(rect_x);
		op.y1 = crt_pkg::edge_t'(rect_y);
		op.x2 = crt_pkg::edge_t'(rect_x) + crt_pkg::edge_t'(rect_w);
		op.y2 = crt_pkg::edge_t'(rect_y) + crt_pkg::edge_t'(rect_h);
	end

	// intersection of entry and cut rectangle
	always_comb begin
		s_a   = e;
		cut.x1 = (nr_q.x1 > s_a.x1) ? nr_q.x1 : s_a.x1;
		cut.y1 = (nr_q.y1 > s_a.y1) ? nr_q.y1 : s_a.y1;
		cut.x2 = (nr_q.x2 < s_a.x2) ? nr_q.x2 : s_a.x2;
		cut.y2 = (nr_q.y2 < s_a.y2) ? nr_q.y2 : s_a.y2;
	end

	// fragment selection: top, bottom, left, right
	always_comb begin
		piece    = a_q;
		piece_ok = 1'b0;
		case (f_q)
			2'd0: begin
				piece.y2 = c_q.y1;
				piece_ok = c_q.y1 > a_q.y1;
			end
			2'd1: begin
				piece.y1 = c_q.y2;
				piece_ok = c_q.y2 < a_q.y2;
			end
			2'd2: begin
				piece.y1 = c_q.y1;
				piece.x2 = c_q.x1;
				piece.y2 = c_q.y2;
				piece_ok = c_q.x1 > a_q.x1;
			end
			default: begin
				piece.x1 = c_q.x2;
				piece.y1 = c_q.y1;
				piece.y2 = c_q.y2;
				piece_ok = c_q.x2 < a_q.x2;
			end
		endcase
	end

	always_comb begin
		push   = 1'b0;
		swdata = crt_pkg::ENT_W'(crt_pkg::rect_to_ent(piece));
		if (state_q == ST_S_EV && !crt_pkg::overlap(e, nr_q)) begin
			push   = 1'b1;
			swdata = mrdata;
		end else if (state_q == ST_S_FR) begin
			push = piece_ok;
		end
		swe    = push && !full;
		swaddr = n_q[AW-1:0];
		sraddr = rev_idx[AW-1:0];
	end

	always_comb begin
		mraddr = i_q[AW-1:0];
		case (state_q)
			ST_SH_RD: mraddr = i_p1[AW-1:0];
			ST_U_RD:  mraddr = i_m1[AW-1:0];
			ST_E_RD:  mraddr = AW'(idx_q);
			default:  mraddr = i_q[AW-1:0];
		endcase
	end

	always_comb begin
		mwe    = 1'b0;
		mwaddr = i_q[AW-1:0];
		mwdata = mrdata;
		case (state_q)
			ST_SH_WR, ST_U_WR: mwe = 1'b1;
			ST_U_RD: begin
				if (i_q <= pos_q) begin
					mwe    = 1'b1;
					mwaddr = pos_q[AW-1:0];
					mwdata = crt_pkg::ENT_W'(crt_pkg::rect_to_ent(nr_q));
				end
			end
			ST_C_WR: begin
				mwe    = 1'b1;
				mwdata = srdata;
			end
			default: mwe = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			i_q       <= '0;
			n_q       <= '0;
			pos_q     <= '0;
			f_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						i_q   <= '0;
						n_q   <= '0;
						nr_q  <= op;
						idx_q <= entry_index;
						case (func)
							crt_pkg::FN_ADD: begin
								state_q <= (rect_w <= 0 || rect_h <= 0) ? ST_B_ST : ST_M_RD;
							end
							crt_pkg::FN_SUB: begin
								state_q <= (rect_w <= 0 || rect_h <= 0 || cnt_q == '0) ?
									ST_B_ST : ST_S_RD;
							end
							crt_pkg::FN_QUERY: state_q <= ST_Q_RD;
							crt_pkg::FN_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_B_ST;
							end
							crt_pkg::FN_SET: begin
								cnt_q   <= '0;
								state_q <= (rect_w <= 0 || rect_h <= 0) ? ST_B_ST : ST_M_RD;
							end
							crt_pkg::FN_READ: begin
								state_q <= (IW'(entry_index) < IW'(cnt_q)) ? ST_E_RD : ST_B_ST;
							end
							default: state_q <= ST_B_ST;
						endcase
					end
				end
				ST_M_RD: begin
					if (i_q >= cnt_q) begin
						i_q     <= '0;
						state_q <= (cnt_q >= CW'(MAX_RECTS)) ? ST_B_ST : ST_P_RD;
					end else begin
						state_q <= ST_M_EV;
					end
				end
				ST_M_EV: begin
					if (crt_pkg::overlap(e, nr_q) || crt_pkg::touch(e, nr_q)) begin
						nr_q    <= crt_pkg::hull(nr_q, e);
						state_q <= ST_SH_RD;
					end else begin
						i_q     <= i_p1;
						state_q <= ST_M_RD;
					end
				end
				ST_SH_RD: begin
					if (i_p1 >= cnt_q) begin
						cnt_q   <= cnt_q - CW'(1);
						i_q     <= '0;
						state_q <= ST_M_RD;
					end else begin
						state_q <= ST_SH_WR;
					end
				end
				ST_SH_WR: begin
					i_q     <= i_p1;
					state_q <= ST_SH_RD;
				end
				ST_P_RD: begin
					if (i_q >= cnt_q) begin
						pos_q   <= i_q;
						i_q     <= cnt_q;
						state_q <= ST_U_RD;
					end else begin
						state_q <= ST_P_EV;
					end
				end
				ST_P_EV: begin
					if (e.y1 <= nr_q.y1) begin
						i_q     <= i_p1;
						state_q <= ST_P_RD;
					end else begin
						pos_q   <= i_q;
						i_q     <= cnt_q;
						state_q <= ST_U_RD;
					end
				end
				ST_U_RD: begin
					if (i_q <= pos_q) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_B_ST;
					end else begin
						state_q <= ST_U_WR;
					end
				end
				ST_U_WR: begin
					i_q     <= i_m1;
					state_q <= ST_U_RD;
				end
				ST_S_RD: begin
					if (i_q >= cnt_q) begin
						i_q     <= '0;
						state_q <= ST_C_RD;
					end else begin
						state_q <= ST_S_EV;
					end
				end
				ST_S_EV: begin
					if (crt_pkg::overlap(e, nr_q)) begin
						a_q     <= e;
						c_q     <= cut;
						f_q     <= '0;
						state_q <= ST_S_FR;
					end else begin
						i_q     <= i_p1;
						state_q <= ST_S_RD;
					end
				end
				ST_S_FR: begin
					f_q <= f_q + 2'd1;
					if (f_q == 2'd3) begin
						i_q     <= i_p1;
						state_q <= ST_S_RD;
					end
				end
				ST_C_RD: begin
					if (i_q >= n_q) begin
						cnt_q   <= n_q;
						state_q <= ST_B_ST;
					end else begin
						state_q <= ST_C_WR;
					end
				end
				ST_C_WR: begin
					i_q     <= i_p1;
					state_q <= ST_C_RD;
				end
				ST_Q_RD: state_q <= (i_q >= cnt_q) ? ST_B_ST : ST_Q_EV;
				ST_Q_EV: begin
					if (crt_pkg::overlap(e, nr_q)) begin
						state_q <= ST_B_ST;
					end else begin
						i_q     <= i_p1;
						state_q <= ST_Q_RD;
					end
				end
				ST_E_RD: state_q <= ST_E_EV;
				ST_E_EV: state_q <= ST_B_ST;
				ST_B_ST: begin
					i_q     <= '0;
					state_q <= ST_B_RD;
				end
				ST_B_RD: state_q <= (i_q >= cnt_q) ? ST_DONE : ST_B_EV;
				ST_B_EV: begin
					i_q     <= i_p1;
					state_q <= ST_B_RD;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (push && !full) begin
				n_q <= n_q + CW'(1);
			end
		end
	end

	// result flags, bounding box and read entry
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			hit_q  <= 1'b0;
			drop_q <= 1'b0;
			ev_q   <= 1'b0;
			ent_q  <= '0;
			bb_q   <= '0;
		end
		if (state_q == ST_M_RD && i_q >= cnt_q && cnt_q >= CW'(MAX_RECTS)) begin
			drop_q <= 1'b1;
		end
		if (push && full) begin
			drop_q <= 1'b1;
		end
		if (state_q == ST_Q_EV && crt_pkg::overlap(e, nr_q)) begin
			hit_q <= 1'b1;
		end
		if (state_q == ST_E_EV) begin
			ev_q  <= 1'b1;
			ent_q <= crt_pkg::ent_t'(mrdata);
		end
		if (state_q == ST_B_EV) begin
			bb_q <= (i_q == '0) ? e : crt_pkg::hull(bb_q, e);
		end
	end

	assign bb_w = bb_q.x2 - bb_q.x1;
	assign bb_h = bb_q.y2 - bb_q.y1;
	assign en_w = crt_pkg::edge_t'(ent_q.x2) - crt_pkg::edge_t'(ent_q.x1);
	assign en_h = crt_pkg::edge_t'(ent_q.y2) - crt_pkg::edge_t'(ent_q.y1);

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid || out_ready)) begin
			hit         <= hit_q;
			dropped     <= drop_q;
			rect_count  <= 7'(cnt_q);
			bbox_x      <= bb_q.x1[15:0];
			bbox_y      <= bb_q.y1[15:0];
			bbox_w      <= bb_w[16:0];
			bbox_h      <= bb_h[16:0];
			entry_valid <= ev_q;
			entry_x     <= ent_q.x1[15:0];
			entry_y     <= ent_q.y1[15:0];
			entry_w     <= en_w[16:0];
			entry_h     <= en_h[16:0];
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_RECTS))
		else $error("stored count above capacity");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mwe && !swe)
		else $error("table written while idle");

	a_result_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the final step");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Clip rectangle region table: a directed table of operations and then about
// 1850 random words. A shadow copy of the rectangle list predicts each result
// word but for directed words that carry their own expected answer, and each
// field is compared in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

	localparam int          DEPTH     = 64;
	localparam int          WD_LIMIT  = 200000;
	localparam int          N_RANDOM  = 1850;
	localparam logic [2:0]  FN_SPARE6 = 3'd6;
	localparam logic [2:0]  FN_SPARE7 = 3'd7;

	typedef struct {
		int x, y, w, h;
	} area_t;

	typedef struct packed {
		logic        hit;
		logic        dropped;
		logic [6:0]  cnt;
		logic [15:0] bx, by;
		logic [16:0] bw, bh;
		logic        ev;
		logic [15:0] ex, ey;
		logic [16:0] ew, eh;
	} answer_t;

	typedef struct {
		logic [2:0] f;
		int         x, y, w, h, idx;
		bit         typed;
		answer_t    want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] func = crt_pkg::FN_QUERY;
	logic signed [15:0] rect_x = '0, rect_y = '0, rect_w = '0, rect_h = '0;
	logic [5:0] entry_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit, dropped, entry_valid;
	logic [6:0] rect_count;
	logic signed [15:0] bbox_x, bbox_y, entry_x, entry_y;
	logic [16:0] bbox_w, bbox_h, entry_w, entry_h;

	area_t   shadow[DEPTH];
	area_t   pieces[DEPTH];
	int      shadow_n = 0;
	int      piece_n;
	answer_t pending_q[$];
	int      idle_in = 35, idle_out = 52;
	bit      hold_req = 0;
	int      hold_left = 0;
	bit      failed = 0;
	int      quiet = 0;
	step_t   plan[$];

	always #5 clk = ~clk;

	clip_rectangle_region_table i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w),
		.rect_h(rect_h), .entry_index(entry_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .dropped(dropped), .rect_count(rect_count),
		.bbox_x(bbox_x), .bbox_y(bbox_y), .bbox_w(bbox_w), .bbox_h(bbox_h),
		.entry_valid(entry_valid), .entry_x(entry_x), .entry_y(entry_y),
		.entry_w(entry_w), .entry_h(entry_h)
	);

	function automatic bit rects_cross(area_t a, area_t b);
		return !(a.x + a.w <= b.x || b.x + b.w <= a.x ||
			a.y + a.h <= b.y || b.y + b.h <= a.y);
	endfunction

	function automatic bit rects_abut(area_t a, area_t b);
		if (a.y == b.y && a.h == b.h && (a.x + a.w == b.x || b.x + b.w == a.x))
			return 1;
		if (a.x == b.x && a.w == b.w && (a.y + a.h == b.y || b.y + b.h == a.y))
			return 1;
		return 0;
	endfunction

	function automatic area_t rect_hull(area_t a, area_t b);
		area_t r;
		int x2, y2;
		x2 = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
		y2 = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
		r.x = (a.x < b.x) ? a.x : b.x;
		r.y = (a.y < b.y) ? a.y : b.y;
		r.w = x2 - r.x;
		r.h = y2 - r.y;
		return r;
	endfunction

	function automatic bit merge_in(area_t nr);
		bit merged;
		int pos;
		if (nr.w <= 0 || nr.h <= 0)
			return 0;
		do begin
			merged = 0;
			for (int i = 0; i < shadow_n; i++) begin
				if (rects_cross(shadow[i], nr) || rects_abut(shadow[i], nr)) begin
					nr = rect_hull(nr, shadow[i]);
					for (int k = i; k + 1 < shadow_n; k++)
						shadow[k] = shadow[k + 1];
					shadow_n--;
					merged = 1;
					break;
				end
			end
		end while (merged);
		if (shadow_n >= DEPTH)
			return 1;
		pos = 0;
		while (pos < shadow_n && shadow[pos].y <= nr.y)
			pos++;
		for (int i = shadow_n; i > pos; i--)
			shadow[i] = shadow[i - 1];
		shadow[pos] = nr;
		shadow_n++;
		return 0;
	endfunction

	function automatic bit stash(area_t b);
		if (piece_n >= DEPTH)
			return 1;
		pieces[piece_n] = b;
		piece_n++;
		return 0;
	endfunction

	function automatic bit carve_out(area_t s);
		bit drop;
		area_t a, f;
		int ax2, ay2, cx1, cy1, cx2, cy2;
		drop = 0;
		piece_n = 0;
		if (s.w <= 0 || s.h <= 0 || shadow_n == 0)
			return 0;
		for (int i = 0; i < shadow_n; i++) begin
			a = shadow[i];
			if (!rects_cross(a, s)) begin
				drop |= stash(a);
				continue;
			end
			ax2 = a.x + a.w;
			ay2 = a.y + a.h;
			cx1 = (s.x > a.x) ? s.x : a.x;
			cy1 = (s.y > a.y) ? s.y : a.y;
			cx2 = (s.x + s.w < ax2) ? s.x + s.w : ax2;
			cy2 = (s.y + s.h < ay2) ? s.y + s.h : ay2;
			if (cy1 > a.y) begin
				f = '{a.x, a.y, a.w, cy1 - a.y};
				drop |= stash(f);
			end
			if (cy2 < ay2) begin
				f = '{a.x, cy2, a.w, ay2 - cy2};
				drop |= stash(f);
			end
			if (cx1 > a.x) begin
				f = '{a.x, cy1, cx1 - a.x, cy2 - cy1};
				drop |= stash(f);
			end
			if (cx2 < ax2) begin
				f = '{cx2, cy1, ax2 - cx2, cy2 - cy1};
				drop |= stash(f);
			end
		end
		for (int i = 0; i < piece_n; i++)
			shadow[i] = pieces[piece_n - 1 - i];
		shadow_n = piece_n;
		return drop;
	endfunction

	function automatic answer_t apply_word(step_t s);
		answer_t r;
		area_t op;
		int x1, y1, x2, y2;
		r = '0;
		op = '{s.x, s.y, s.w, s.h};
		case (s.f)
			crt_pkg::FN_ADD: r.dropped = merge_in(op);
			crt_pkg::FN_SUB: r.dropped = carve_out(op);
			crt_pkg::FN_QUERY: begin
				for (int i = 0; i < shadow_n; i++)
					if (rects_cross(shadow[i], op)) begin
						r.hit = 1;
						break;
					end
			end
			crt_pkg::FN_CLEAR: shadow_n = 0;
			crt_pkg::FN_SET: begin
				shadow_n = 0;
				r.dropped = merge_in(op);
			end
			crt_pkg::FN_READ: begin
				if (s.idx < shadow_n) begin
					r.ev = 1;
					r.ex = shadow[s.idx].x[15:0];
					r.ey = shadow[s.idx].y[15:0];
					r.ew = shadow[s.idx].w[16:0];
					r.eh = shadow[s.idx].h[16:0];
				end
			end
			default: ;
		endcase
		if (shadow_n > 0) begin
			x1 = shadow[0].x;
			y1 = shadow[0].y;
			x2 = x1 + shadow[0].w;
			y2 = y1 + shadow[0].h;
			for (int i = 1; i < shadow_n; i++) begin
				if (shadow[i].x < x1) x1 = shadow[i].x;
				if (shadow[i].y < y1) y1 = shadow[i].y;
				if (shadow[i].x + shadow[i].w > x2) x2 = shadow[i].x + shadow[i].w;
				if (shadow[i].y + shadow[i].h > y2) y2 = shadow[i].y + shadow[i].h;
			end
			r.bx = x1[15:0];
			r.by = y1[15:0];
			r.bw = 17'(x2 - x1);
			r.bh = 17'(y2 - y1);
		end
		r.cnt = 7'(shadow_n);
		return r;
	endfunction

	function automatic step_t mk(logic [2:0] f, int x, int y, int w, int h, int idx);
		step_t s;
		s.f = f; s.x = x; s.y = y; s.w = w; s.h = h; s.idx = idx;
		s.typed = 0;
		s.want = '0;
		return s;
	endfunction

	function automatic step_t mk_typed(logic [2:0] f, int x, int y, int w, int h,
			int cnt, int bx, int by, int bw, int bh);
		step_t s;
		s = mk(f, x, y, w, h, 0);
		s.typed = 1;
		s.want.cnt = 7'(cnt);
		s.want.bx = 16'(bx);
		s.want.by = 16'(by);
		s.want.bw = 17'(bw);
		s.want.bh = 17'(bh);
		return s;
	endfunction

	function automatic int rand16();
		return int'($signed(16'($urandom)));
	endfunction

	function automatic step_t rand_step();
		step_t s;
		int sel;
		sel = $urandom_range(0, 999);
		if (sel < 450) s.f = crt_pkg::FN_ADD;
		else if (sel < 600) s.f = crt_pkg::FN_SUB;
		else if (sel < 750) s.f = crt_pkg::FN_QUERY;
		else if (sel < 880) s.f = crt_pkg::FN_READ;
		else if (sel < 890) s.f = crt_pkg::FN_CLEAR;
		else if (sel < 920) s.f = crt_pkg::FN_SET;
		else if (sel < 940) s.f = ($urandom_range(0, 1)) ? FN_SPARE6 : FN_SPARE7;
		else s.f = crt_pkg::FN_ADD;
		s.idx = $urandom_range(0, 63);
		if ($urandom_range(0, 9) == 0) begin
			s.x = rand16(); s.y = rand16(); s.w = rand16(); s.h = rand16();
		end else begin
			s.x = $urandom_range(0, 15) * 8 + $urandom_range(0, 3);
			s.y = $urandom_range(0, 15) * 8 + $urandom_range(0, 3);
			s.w = $urandom_range(1, 12);
			s.h = $urandom_range(1, 12);
			if (s.f == crt_pkg::FN_SUB) begin
				s.w = s.w * 3;
				s.h = s.h * 3;
			end
			if ($urandom_range(0, 29) == 0)
				s.w = -$urandom_range(0, 5);
		end
		s.typed = 0;
		s.want = '0;
		return s;
	endfunction

	task automatic send_word(step_t s);
		answer_t r;
		while ($urandom_range(0, 99) < idle_in) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= s.f;
		rect_x <= 16'(s.x);
		rect_y <= 16'(s.y);
		rect_w <= 16'(s.w);
		rect_h <= 16'(s.h);
		entry_index <= 6'(s.idx);
		do
			@(posedge clk);
		while (!in_ready);
		r = apply_word(s);
		pending_q.push_back(s.typed ? s.want : r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (pending_q.size() == 0);
		@(posedge clk);
	endtask

	function automatic void check_field(string name, longint e, longint a);
		if (e != a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			failed = 1;
		end
	endfunction

	always @(posedge clk) begin
		answer_t e;
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("result word with nothing pending");
				failed = 1;
			end else begin
				e = pending_q.pop_front();
				check_field("hit", e.hit, hit);
				check_field("dropped", e.dropped, dropped);
				check_field("rect_count", e.cnt, rect_count);
				check_field("bbox_x", e.bx, $unsigned(bbox_x));
				check_field("bbox_y", e.by, $unsigned(bbox_y));
				check_field("bbox_w", e.bw, bbox_w);
				check_field("bbox_h", e.bh, bbox_h);
				check_field("entry_valid", e.ev, entry_valid);
				check_field("entry_x", e.ex, $unsigned(entry_x));
				check_field("entry_y", e.ey, $unsigned(entry_y));
				check_field("entry_w", e.ew, entry_w);
				check_field("entry_h", e.eh, entry_h);
			end
		end
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= idle_out);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WD_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		plan.push_back(mk_typed(crt_pkg::FN_QUERY, 0, 0, 10, 10, 0, 0, 0, 0, 0));
		plan.push_back(mk_typed(crt_pkg::FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk_typed(crt_pkg::FN_ADD, 0, 0, -5, 10, 0, 0, 0, 0, 0));
		plan.push_back(mk_typed(crt_pkg::FN_ADD, 0, 0, 5, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk_typed(crt_pkg::FN_SUB, 0, 0, 5, 5, 0, 0, 0, 0, 0));
		plan.push_back(mk_typed(crt_pkg::FN_ADD, 0, 0, 10, 10, 1, 0, 0, 10, 10));
		plan.push_back(mk_typed(crt_pkg::FN_ADD, 10, 0, 10, 10, 1, 0, 0, 20, 10));
		plan.push_back(mk(crt_pkg::FN_ADD, 5, 5, 10, 10, 0));
		plan.push_back(mk(crt_pkg::FN_ADD, 100, 100, 5, 5, 0));
		plan.push_back(mk(crt_pkg::FN_QUERY, 1, 1, 1, 1, 0));
		plan.push_back(mk(crt_pkg::FN_QUERY, 5, 5, -3, -3, 0));
		plan.push_back(mk(crt_pkg::FN_SUB, 2, 2, 3, 3, 0));
		plan.push_back(mk(crt_pkg::FN_READ, 0, 0, 0, 0, 0));
		plan.push_back(mk(crt_pkg::FN_READ, 0, 0, 0, 0, 63));
		plan.push_back(mk(FN_SPARE6, 1, 2, 3, 4, 5));
		plan.push_back(mk(FN_SPARE7, -1, -1, -1, -1, 63));
		plan.push_back(mk_typed(crt_pkg::FN_SET, -32768, -32768, 32767, 32767,
			1, -32768, -32768, 32767, 32767));
		plan.push_back(mk(crt_pkg::FN_ADD, 32767, 32767, 32767, 32767, 0));
		plan.push_back(mk(crt_pkg::FN_READ, 0, 0, 0, 0, 1));
		plan.push_back(mk(crt_pkg::FN_ADD, 32000, 0, 32767, 10, 0));
		plan.push_back(mk(crt_pkg::FN_SUB, 32000, 0, 1000, 10, 0));
		plan.push_back(mk(crt_pkg::FN_READ, 0, 0, 0, 0, 0));
		plan.push_back(mk(crt_pkg::FN_READ, 0, 0, 0, 0, 2));
		plan.push_back(mk_typed(crt_pkg::FN_SET, 5, 5, 0, 9, 0, 0, 0, 0, 0));
		plan.push_back(mk(crt_pkg::FN_ADD, 1, 1, 1, 1, 0));
		plan.push_back(mk_typed(crt_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_word(plan[i]);

		for (int ph = 0; ph < 3; ph++) begin
			drain();
			idle_in = (ph == 0) ? 35 : (ph == 1) ? 52 : 0;
			idle_out = (ph == 0) ? 52 : (ph == 1) ? 35 : 0;
			if (ph == 1)
				hold_req = 1;
			for (int n = 0; n < N_RANDOM / 3; n++)
				send_word(rand_step());
		end

		in_valid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (200) @(posedge clk);
		if (!failed && pending_q.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

### clip_rectangle_region_table.f
rtl/core/crt_pkg.sv
rtl/core/crt_ram.sv
rtl/core/clip_rectangle_region_table.sv
tb/sv/tb.sv
